// ----- rtl/bpc_pkg.sv -----
// Package for the button press classifier.
// Holds sizes, register indexes and the structs shared by the registers, the lanes and the merge stage.
// No dependencies.
`timescale 1ns / 1ps

package bpc_pkg;

  // Number of buttons, one lane each.
  localparam int NUM_BUTTONS = 2;
  // Width of the per-button fields on the stream ports.
  localparam int FIELD_W     = 2;
  // Width of a hold counter and of the threshold registers.
  localparam int CNT_W       = 16;

  // Padded stream data widths.
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 8;

  // Configuration bus.
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // Register indexes, taken from the word address.
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  // Reset values of the threshold registers.
  localparam logic [CNT_W-1:0] DEBOUNCE_RESET   = 16'd100;
  localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd2000;

  // Threshold values seen by every lane.
  typedef struct packed {
    logic [CNT_W-1:0] debounce_count;
    logic [CNT_W-1:0] long_press_count;
  } cfg_t;

  // What one lane found on one tick.
  typedef struct packed {
    logic short_ev;
    logic long_ev;
  } lane_ev_t;

endpackage

// ----- rtl/bpc_regs.sv -----
// Configuration registers of the button press classifier on an APB-style port.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_regs import bpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  logic [CNT_W-1:0] debounce_r;
  logic [CNT_W-1:0] long_press_r;
  logic             wr_en;
  logic             reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[2];

  // Register writes in the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEBOUNCE:   debounce_r   <= cfg_pwdata[CNT_W-1:0];
        REG_LONG_PRESS: long_press_r <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero-extended to the bus width.
  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:   cfg_prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, debounce_r};
      REG_LONG_PRESS: cfg_prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, long_press_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg.debounce_count   = debounce_r;
  assign cfg.long_press_count = long_press_r;

endmodule

// ----- rtl/bpc_lane.sv -----
// One button lane: hold counter and short/long press detection.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_lane import bpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  logic     level,
  input  cfg_t     cfg,
  output lane_ev_t ev
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             pressed;

  assign pressed = ~level;

  // Counter step and event decode for the sampled level.
  always_comb begin
    ev      = '0;
    cnt_nxt = cnt_r;
    if (pressed) begin
      if (cnt_r == cfg.long_press_count) begin
        ev.long_ev = 1'b1;
        if (cnt_r != {CNT_W{1'b1}}) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end else if (cnt_r < cfg.long_press_count) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      ev.short_ev = (cnt_r < cfg.long_press_count) && (cnt_r > cfg.debounce_count);
      cnt_nxt     = '0;
    end
  end

  // The counter moves only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  // A tick never ends a short press and reaches the long count at once.
  a_ev_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ev.short_ev && ev.long_ev))
    else $error("lane reports short and long event together");

  // A released button starts over from zero.
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && level) |=> (cnt_r == '0))
    else $error("counter not cleared on release");

  // Reaching the long count steps the counter one further unless saturated.
  a_long_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ev.long_ev && (cnt_r != {CNT_W{1'b1}})) |=>
      (cnt_r == $past(cnt_r) + 1'b1))
    else $error("counter did not step past the long count");

  // Without an accepted tick the counter holds.
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(cnt_r))
    else $error("counter moved without an accepted tick");
`endif

endmodule

// ----- rtl/bpc_merge.sv -----
// Merge stage: packs the lane events into one result and holds it in the output register.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_merge import bpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  lane_ev_t              lane_ev [NUM_BUTTONS],
  output logic                  busy,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic                  valid_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic [FIELD_W-1:0]    short_mask;
  logic [FIELD_W-1:0]    long_mask;

  // Gather one bit per lane; bits beyond the button count stay zero.
  always_comb begin
    short_mask = '0;
    long_mask  = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      short_mask[b] = lane_ev[b].short_ev;
      long_mask[b]  = lane_ev[b].long_ev;
    end
  end

  // The register is free when empty or when its result is taken this cycle.
  assign busy = valid_r & ~out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= {{(OUT_DATA_W-2*FIELD_W){1'b0}}, long_mask, short_mask};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

// ----- rtl/button_press_classifier.sv -----
// Top level of the button press classifier: registers, one lane per button, merge stage.
// Depends on bpc_pkg, bpc_regs, bpc_lane and bpc_merge.
//
// Channel   Direction  Handshake               Content
// in_       slave      in_tvalid / in_tready   one scan tick of button levels
// out_      master     out_tvalid / out_tready one short mask and one long mask
// cfg_      APB slave  psel / penable / pready debounce and long press counts
//
// One tick per clock unless the output stalls; its result appears in the output register the next cycle.
// The lanes update their counters in the accept cycle and the merge register holds the result.
// A new tick is taken while the output register is empty or being drained the same cycle.
// Reset is synchronous and active low; counters clear and thresholds return to 100 and 2000.
`timescale 1ns / 1ps

module button_press_classifier import bpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [1:0] button_levels, [7:2] zero
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [1:0] short_events, [3:2] long_events, [7:4] zero
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t     cfg;
  lane_ev_t lane_ev [NUM_BUTTONS];
  logic     busy;
  logic     accept;

  assign in_tready = ~busy;
  assign accept    = in_tvalid & in_tready;

  // Threshold registers.
  bpc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // One lane per button.
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    bpc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .accept (accept),
      .level  (in_tdata[b]),
      .cfg    (cfg),
      .ev     (lane_ev[b])
    );
  end

  // Combine the lane events into the result register.
  bpc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .lane_ev    (lane_ev),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
